FILE: hw/rtl/eaps_pkg.sv
`timescale 1ns / 1ps
package eaps_pkg;

  // fixed field widths
  localparam int ANGLE_BITS        = 16;
  localparam int COORD_BITS        = 24;
  localparam int RADIUS_BITS       = COORD_BITS - 1;
  localparam int INDEX_BITS        = 12;
  localparam int COUNT_BITS        = 13;
  localparam int MAX_POINTS        = 4096;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  // divider: numerator 2*idx*span + den, divisor 2*den
  localparam int NUM_BITS = 30;
  localparam int REM_BITS = 13;
  localparam int Q_BITS   = ANGLE_BITS;

  // rotator datapath, Q2.30 with headroom
  localparam int VEC_BITS = 34;
  localparam logic signed [VEC_BITS-1:0] CORDIC_GAIN = 34'sd652032874;

  // config register indexes
  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_RADIUS_X    = 3'd2;
  localparam logic [2:0] REG_RADIUS_Y    = 3'd3;
  localparam logic [2:0] REG_START_ANGLE = 3'd4;
  localparam logic [2:0] REG_END_ANGLE   = 3'd5;
  localparam logic [2:0] REG_POINT_COUNT = 3'd6;

  typedef struct packed {
    logic                v;
    logic                err;
    logic [REM_BITS-1:0] rem;
    logic [NUM_BITS-1:0] num;
    logic [Q_BITS-1:0]   q;
  } div_word_t;

  typedef struct packed {
    logic                       v;
    logic                       err;
    logic                       neg;
    logic signed [VEC_BITS-1:0] x;
    logic signed [VEC_BITS-1:0] y;
    logic signed [VEC_BITS-1:0] z;
  } rot_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         err;
  } point_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/eaps_div_cell.sv
`timescale 1ns / 1ps
module eaps_div_cell import eaps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [REM_BITS-1:0] divisor,
  input  div_word_t           din,
  output div_word_t           dout
);

  logic [REM_BITS:0] trial;
  logic              take;
  div_word_t         dout_next;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    trial            = {din.rem, din.num[NUM_BITS-1]};
    take             = (trial >= {1'b0, divisor});
    dout_next        = din;
    dout_next.rem    = take ? REM_BITS'(trial - {1'b0, divisor}) : trial[REM_BITS-1:0];
    dout_next.num    = {din.num[NUM_BITS-2:0], 1'b0};
    dout_next.q      = {din.q[Q_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.v <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: hw/rtl/eaps_rot_cell.sv
`timescale 1ns / 1ps
module eaps_rot_cell import eaps_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  rot_word_t din,
  output rot_word_t dout
);

  localparam logic signed [VEC_BITS-1:0] ATAN =
    $signed({{(VEC_BITS-32){1'b0}}, atan_turn(STEP)});

  rot_word_t dout_next;
  logic signed [VEC_BITS-1:0] dx, dy;

  // one micro-rotation toward zero residual angle
  always_comb begin
    dx        = din.y >>> STEP;
    dy        = din.x >>> STEP;
    dout_next = din;
    if (!din.z[VEC_BITS-1]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - ATAN;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.v <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: hw/rtl/eaps_skid.sv
`timescale 1ns / 1ps
module eaps_skid import eaps_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  point_t in_word,
  output logic   out_valid,
  input  logic   out_ready,
  output point_t out_word
);

  logic   skid_valid;
  point_t skid_word;

  assign in_ready = !skid_valid;

  // output register plus one spare entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        out_word  <= in_word;
      end
    end else if (in_valid && !skid_valid) begin
      skid_word  <= in_word;
      skid_valid <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/elliptic_arc_point_sampler_unit.sv
`timescale 1ns / 1ps
// Elliptic arc point sampler.
// Input channel sample_valid/sample_ready carries one word, sample_index.
// Output channel point_valid/point_ready returns one word per input:
// point_x, point_y (signed Q15.8, saturated) and index_error.
// Configure through cfg_we/cfg_addr/cfg_wdata while no word is in flight.
// Datapath: one setup stage (count clamp, index*span product), a chain of
// 30 restoring divider cells (one quotient bit each), a quadrant stage,
// CORDIC_STAGES rotation cells, a multiply stage by the semi-axes, then the
// center add with saturation into the output register.
// Throughput: one word per cycle while the chain is not held; every cell
// passes its word on each cycle in which the chain is enabled.
// When point_ready is low the output register holds the word and a spare
// entry takes one more; then sample_ready drops and the whole chain holds.
// Reset clears all valid bits; config registers to zero, point_count to 2.
module elliptic_arc_point_sampler_unit import eaps_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_addr,
  input  logic [COORD_BITS-1:0]        cfg_wdata,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  input  logic [INDEX_BITS-1:0]        sample_index,
  output logic                         point_valid,
  input  logic                         point_ready,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic                         index_error
);

  // configuration registers
  logic signed [COORD_BITS-1:0] center_x, center_y;
  logic [RADIUS_BITS-1:0]       radius_x, radius_y;
  logic [ANGLE_BITS-1:0]        start_angle, end_angle;
  logic [COUNT_BITS-1:0]        point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      radius_x    <= '0;
      radius_y    <= '0;
      start_angle <= '0;
      end_angle   <= '0;
      point_count <= COUNT_BITS'(2);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CENTER_X:    center_x    <= cfg_wdata;
        REG_CENTER_Y:    center_y    <= cfg_wdata;
        REG_RADIUS_X:    radius_x    <= cfg_wdata[RADIUS_BITS-1:0];
        REG_RADIUS_Y:    radius_y    <= cfg_wdata[RADIUS_BITS-1:0];
        REG_START_ANGLE: start_angle <= cfg_wdata[ANGLE_BITS-1:0];
        REG_END_ANGLE:   end_angle   <= cfg_wdata[ANGLE_BITS-1:0];
        REG_POINT_COUNT: point_count <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // derived config: clamped count, divisor, span
  logic [COUNT_BITS-1:0] count_eff;
  logic [INDEX_BITS-1:0] den;
  logic [REM_BITS-1:0]   den2;
  logic [ANGLE_BITS-1:0] span;

  always_comb begin
    if (point_count < COUNT_BITS'(2))
      count_eff = COUNT_BITS'(2);
    else if (point_count > COUNT_BITS'(MAX_POINTS))
      count_eff = COUNT_BITS'(MAX_POINTS);
    else
      count_eff = point_count;
    den  = INDEX_BITS'(count_eff - COUNT_BITS'(1));
    den2 = {den, 1'b0};
    span = end_angle - start_angle;
  end

  logic en;
  logic tail_ready;
  assign en           = tail_ready;
  assign sample_ready = en;

  // setup stage: numerator 2*idx*span + den
  div_word_t div_chain [NUM_BITS+1];
  logic [INDEX_BITS+ANGLE_BITS-1:0] idx_span;
  div_word_t setup_next;

  always_comb begin
    idx_span       = sample_index * span;
    setup_next.v   = sample_valid;
    setup_next.err = ({1'b0, sample_index} >= count_eff);
    setup_next.rem = '0;
    setup_next.num = NUM_BITS'({idx_span, 1'b0}) + NUM_BITS'(den);
    setup_next.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_chain[0].v <= 1'b0;
    end else if (en) begin
      div_chain[0] <= setup_next;
    end
  end

  // divider chain
  for (genvar i = 0; i < NUM_BITS; i++) begin : g_div
    eaps_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .divisor(den2),
      .din    (div_chain[i]),
      .dout   (div_chain[i+1])
    );
  end

  // quadrant fold: angles in [1/4, 3/4) turn rotate by half a turn
  rot_word_t rot_chain [CORDIC_STAGES+1];
  rot_word_t fold_next;
  logic [ANGLE_BITS-1:0] angle;
  logic                  fold;

  always_comb begin
    angle         = start_angle + div_chain[NUM_BITS].q;
    fold          = angle[ANGLE_BITS-1] ^ angle[ANGLE_BITS-2];
    fold_next.v   = div_chain[NUM_BITS].v;
    fold_next.err = div_chain[NUM_BITS].err;
    fold_next.neg = fold;
    fold_next.x   = CORDIC_GAIN;
    fold_next.y   = '0;
    fold_next.z   = VEC_BITS'($signed({angle[ANGLE_BITS-1] ^ fold,
                                       angle[ANGLE_BITS-2:0],
                                       {(32-ANGLE_BITS){1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_chain[0].v <= 1'b0;
    end else if (en) begin
      rot_chain[0] <= fold_next;
    end
  end

  // rotation chain
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    eaps_rot_cell #(.STEP(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .din (rot_chain[i]),
      .dout(rot_chain[i+1])
    );
  end

  // scale by the semi-axes
  localparam int PROD_BITS = COORD_BITS + 32;
  logic signed [31:0]          cos_v, sin_v;
  logic signed [PROD_BITS-1:0] prod_x, prod_y;
  logic                        mul_v, mul_err;

  always_comb begin
    cos_v = rot_chain[CORDIC_STAGES].neg ? 32'(-rot_chain[CORDIC_STAGES].x)
                                         : 32'(rot_chain[CORDIC_STAGES].x);
    sin_v = rot_chain[CORDIC_STAGES].neg ? 32'(-rot_chain[CORDIC_STAGES].y)
                                         : 32'(rot_chain[CORDIC_STAGES].y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else if (en) begin
      mul_v <= rot_chain[CORDIC_STAGES].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_err <= rot_chain[CORDIC_STAGES].err;
      prod_x  <= $signed({1'b0, radius_x}) * cos_v;
      prod_y  <= $signed({1'b0, radius_y}) * sin_v;
    end
  end

  // round, add center, saturate
  localparam int SUM_BITS = PROD_BITS - 30 + 1;
  localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((1 << (COORD_BITS-1)) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);
  localparam logic signed [PROD_BITS-1:0] RND = PROD_BITS'(1) <<< 29;

  logic signed [PROD_BITS-1:0] rx, ry;
  logic signed [SUM_BITS-1:0]  sx, sy;
  point_t                      fin;

  always_comb begin
    rx = (prod_x + RND) >>> 30;
    ry = (prod_y + RND) >>> 30;
    sx = SUM_BITS'(rx) + SUM_BITS'(center_x);
    sy = SUM_BITS'(ry) + SUM_BITS'(center_y);
    if (sx > SAT_HI)      fin.x = SAT_HI[COORD_BITS-1:0];
    else if (sx < SAT_LO) fin.x = SAT_LO[COORD_BITS-1:0];
    else                  fin.x = sx[COORD_BITS-1:0];
    if (sy > SAT_HI)      fin.y = SAT_HI[COORD_BITS-1:0];
    else if (sy < SAT_LO) fin.y = SAT_LO[COORD_BITS-1:0];
    else                  fin.y = sy[COORD_BITS-1:0];
    fin.err = mul_err;
    if (mul_err) begin
      fin.x = '0;
      fin.y = '0;
    end
  end

  point_t out_word;

  eaps_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mul_v),
    .in_ready (tail_ready),
    .in_word  (fin),
    .out_valid(point_valid),
    .out_ready(point_ready),
    .out_word (out_word)
  );

  assign point_x     = out_word.x;
  assign point_y     = out_word.y;
  assign index_error = out_word.err;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    point_valid && index_error |-> point_x == '0 && point_y == '0)
    else $error("error word carries a nonzero point");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    !en |-> point_valid)
    else $error("chain held while the output register is empty");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    !en && mul_v |=> $stable(fin))
    else $error("tail word changed while the chain was held");

endmodule
